// ----- rtl/tfd_pkg.sv -----
package tfd_pkg;

   typedef enum logic [1:0] {
      MODE_PASS   = 2'd0,
      MODE_HALF   = 2'd1,
      MODE_PACKED = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   localparam logic [31:0] F32_INF = 32'h7f80_0000;
   localparam logic [31:0] F32_ONE = 32'h3f80_0000;
   localparam int unsigned LANES = 4;

   // Conversion kind that one lane applies to its slice of the word.
   typedef enum logic [1:0] {
      CONV_PASS  = 2'd0,
      CONV_HALF  = 2'd1,
      CONV_UF    = 2'd2,
      CONV_ONE   = 2'd3
   } conv_type;

   // One lane's input: a slice of the word, right aligned, and how to read it.
   typedef struct packed {
      logic [31:0] bits;
      conv_type    conv;
      logic        mant6;
   } lane_in_type;

endpackage

// ----- rtl/tfd_lane.sv -----
module tfd_lane
   import tfd_pkg::*;
(
   input  lane_in_type lane_in,
   output logic [31:0] float_bits
);

   logic [15:0] h;
   logic        sgn;
   logic [4:0]  e;
   logic [9:0]  m;
   logic [3:0]  p;
   logic [9:0]  frac;
   logic [7:0]  sub_exp;

   always_comb begin
      h   = lane_in.bits[15:0];
      sgn = 1'b0;
      e   = 5'd0;
      m   = 10'd0;
      unique case (lane_in.conv)
         CONV_HALF: begin
            sgn = h[15];
            e   = h[14:10];
            m   = h[9:0];
         end
         CONV_UF: begin
            if (lane_in.mant6) begin
               e = h[10:6];
               m = {h[5:0], 4'd0};
            end else begin
               e = h[9:5];
               m = {h[4:0], 5'd0};
            end
         end
         default: begin
         end
      endcase
      // Highest set bit of the left-aligned mantissa.
      p = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (m[i]) p = 4'(i);
      end
      frac    = 10'(m << (4'd10 - p));
      sub_exp = 8'(8'd103 + {4'd0, p});
      unique case (lane_in.conv)
         CONV_PASS: float_bits = lane_in.bits;
         CONV_ONE:  float_bits = F32_ONE;
         default: begin
            if (e == 5'd0) begin
               if (m == 10'd0) float_bits = {sgn, 31'd0};
               else float_bits = {sgn, sub_exp, frac, 13'd0};
            end else if (e == 5'd31) begin
               if (lane_in.conv == CONV_UF) float_bits = F32_INF;
               else float_bits = {sgn, 8'hff, m, 13'd0};
            end else begin
               float_bits = {sgn, 8'({3'd0, e} + 8'd112), m, 13'd0};
            end
         end
      endcase
   end

endmodule

// ----- rtl/tfd_merge.sv -----
module tfd_merge
   import tfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic [31:0]       lane_bits [LANES],
   input  logic [2:0]        count,
   input  logic              rsp_stall,
   output logic              busy,
   output logic              rsp_valid,
   output logic [31:0]       rsp_float_bits,
   output logic [1:0]        rsp_channel_index,
   output logic              rsp_last_of_word
);

   logic [31:0] hold_ff [LANES];
   logic [2:0]  count_ff, count_in;
   logic [1:0]  idx_ff, idx_in;
   logic        done;

   assign rsp_valid         = count_ff != 3'd0;
   assign rsp_float_bits    = hold_ff[idx_ff];
   assign rsp_channel_index = idx_ff;
   assign rsp_last_of_word  = 3'({1'b0, idx_ff} + 3'd1) == count_ff;
   assign done              = rsp_valid && !rsp_stall && rsp_last_of_word;
   // Busy unless the buffer is empty or its final result leaves this cycle.
   assign busy              = rsp_valid && !done;

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      if (load) begin
         count_in = count;
         idx_in   = 2'd0;
      end else if (done) begin
         count_in = 3'd0;
      end else if (rsp_valid && !rsp_stall) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
         idx_ff   <= 2'd0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
      if (load) begin
         for (int i = 0; i < LANES; i++) hold_ff[i] <= lane_bits[i];
      end
   end

endmodule

// ----- rtl/texel_format_to_float32_decoder.sv -----
// Channel  Ports                                                          Direction
// req      req_valid, req_stall, req_source_word                          in
// rsp      rsp_valid, rsp_stall, rsp_float_bits, rsp_channel_index, rsp_last_of_word  out
// csr      csr_write, csr_format_mode                                     in
// Four conversion lanes decode a whole word in the cycle it is accepted and the
// results land in a four-entry hold buffer; the result port then drains them one
// per cycle while rsp_stall is low. A word gives 1, 2 or 4 results (passthrough,
// half, packed) through the single result port. The next word is accepted in the
// cycle the previous word's last result leaves. Reset is synchronous and sets
// passthrough. A word in the unused format is accepted and dropped.
module texel_format_to_float32_decoder
   import tfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_source_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_float_bits,
   output logic [1:0]  rsp_channel_index,
   output logic        rsp_last_of_word,
   input  logic        csr_write,
   input  logic [1:0]  csr_format_mode
);

   logic [1:0]  mode_ff;
   lane_in_type lane_in [LANES];
   logic [31:0] lane_bits [LANES];
   logic [2:0]  count;
   logic        busy;
   logic        load;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= MODE_PASS;
      else if (csr_write) mode_ff <= csr_format_mode;
   end

   assign req_stall = busy;
   assign load      = req_valid && !busy;

   // Slice the word for each lane according to the format.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         lane_in[i].bits  = req_source_word;
         lane_in[i].conv  = CONV_PASS;
         lane_in[i].mant6 = 1'b1;
      end
      count = 3'd0;
      unique case (mode_type'(mode_ff))
         MODE_PASS: count = 3'd1;
         MODE_HALF: begin
            count = 3'd2;
            lane_in[0].conv = CONV_HALF;
            lane_in[0].bits = {16'd0, req_source_word[15:0]};
            lane_in[1].conv = CONV_HALF;
            lane_in[1].bits = {16'd0, req_source_word[31:16]};
         end
         MODE_PACKED: begin
            count = 3'd4;
            lane_in[0].conv = CONV_UF;
            lane_in[0].bits = {21'd0, req_source_word[10:0]};
            lane_in[1].conv = CONV_UF;
            lane_in[1].bits = {21'd0, req_source_word[21:11]};
            lane_in[2].conv  = CONV_UF;
            lane_in[2].mant6 = 1'b0;
            lane_in[2].bits  = {22'd0, req_source_word[31:22]};
            lane_in[3].conv = CONV_ONE;
         end
         default: count = 3'd0;
      endcase
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      tfd_lane u_lane (
         .lane_in    (lane_in[g]),
         .float_bits (lane_bits[g])
      );
   end

   tfd_merge u_merge (
      .clock             (clock),
      .reset             (reset),
      .load              (load),
      .lane_bits         (lane_bits),
      .count             (count),
      .rsp_stall         (rsp_stall),
      .busy              (busy),
      .rsp_valid         (rsp_valid),
      .rsp_float_bits    (rsp_float_bits),
      .rsp_channel_index (rsp_channel_index),
      .rsp_last_of_word  (rsp_last_of_word)
   );

endmodule
